>>> hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition that must never be true on a rising clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/uemf_pkg.sv
// types and constants of the echo median filter
package uemf_pkg;

    localparam int ECHO_W     = 15;
    localparam int DIST_W     = 18;
    localparam int STATUS_W   = 2;
    localparam int VCOUNT_W   = 3;
    localparam int THRESH_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int SCALE_W    = 13;
    localparam int PROD_W     = ECHO_W + SCALE_W;
    localparam int SCALE_SHIFT = 10;

    localparam logic [SCALE_W-1:0] SCALE_MUL = 13'd4496;

    localparam logic [STATUS_W-1:0] STATUS_GOOD = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WARN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OK_MIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_MIN  = 2'd3;

    localparam logic [DIST_W-1:0]   MIN_DIST_RST = 18'd512;
    localparam logic [DIST_W-1:0]   MAX_DIST_RST = 18'd102400;
    localparam logic [THRESH_W-1:0] OK_MIN_RST   = 3'd5;
    localparam logic [THRESH_W-1:0] WARN_MIN_RST = 3'd3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef struct packed {
        logic [DIST_W-1:0] dist_q8;
        logic              ok;
    } sample_t;

    typedef struct packed {
        logic [THRESH_W-1:0] ok_min;
        logic [THRESH_W-1:0] warn_min;
    } thresh_t;

    typedef struct packed {
        logic [DIST_W-1:0] min_dist;
        logic [DIST_W-1:0] max_dist;
    } bounds_t;

endpackage

>>> hdl/ultrasonic_echo_median_filter_unit.sv
// top level of the ultrasonic echo median filter
// Takes echo widths in microseconds, converts each to a q8 distance in cm
// and gives one word per batch of BATCH_SIZE echoes: the median of the
// in-range samples (on error, the last median again), a status and the
// valid count. The front converts and range-checks one word per cycle,
// while the queue is not full, into a two-entry queue; the back takes one
// sample per cycle from it while loading, then ranks the batch with a
// sequencer that visits one stored sample per cycle and, in the emit state,
// loads the result register once it is empty or being popped. A new echo
// is taken while a finished result waits to be popped, if the queue has room.
// The user must write registers through wr_en/wr_index/wr_data only while
// the unit is idle; the block itself does not enforce this.
module ultrasonic_echo_median_filter_unit import uemf_pkg::*;
#(
    parameter int BATCH_SIZE = 5
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [ECHO_W-1:0]      echo_us,
    output logic                   empty,
    input  logic                   pop,
    output logic [DIST_W-1:0]      distance_q8,
    output logic [STATUS_W-1:0]    status,
    output logic [VCOUNT_W-1:0]    valid_count,
    input  logic                   wr_en,
    input  logic [CFG_IDX_W-1:0]   wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

`include "assert_macros.svh"

    bounds_t bounds_reg;
    thresh_t thresh_reg;

    logic    q_full;
    logic    q_push;
    sample_t q_push_word;
    logic    q_empty;
    logic    q_pop;
    sample_t q_pop_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.min_dist <= MIN_DIST_RST;
            bounds_reg.max_dist <= MAX_DIST_RST;
            thresh_reg.ok_min   <= OK_MIN_RST;
            thresh_reg.warn_min <= WARN_MIN_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MIN_DIST: bounds_reg.min_dist <= wr_data;
                REG_MAX_DIST: bounds_reg.max_dist <= wr_data;
                REG_OK_MIN:   thresh_reg.ok_min   <= wr_data[THRESH_W-1:0];
                REG_WARN_MIN: thresh_reg.warn_min <= wr_data[THRESH_W-1:0];
                default:      ;
            endcase
        end
    end

    uemf_front u_front
    (
        .push    (push),
        .full    (full),
        .echo_us (echo_us),
        .bounds  (bounds_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_word  (q_push_word)
    );

    uemf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_word  (q_pop_word)
    );

    uemf_back #(
        .BATCH_SIZE (BATCH_SIZE)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_word      (q_pop_word),
        .q_pop       (q_pop),
        .thresh      (thresh_reg),
        .empty       (empty),
        .pop         (pop),
        .distance_q8 (distance_q8),
        .status      (status),
        .valid_count (valid_count)
    );

    // an ok word always carries at least one valid sample
    `ASSERT_CLK(a_ok_has_samples,
        (!empty && status == STATUS_GOOD) |-> (valid_count != '0),
        "ok word with no valid samples")
    // the valid count never exceeds the batch
    `ASSERT_NEVER(a_count_bound, !empty && (int'(valid_count) > BATCH_SIZE),
        "valid count above batch size")
    // the back never drains an empty queue
    `ASSERT_NEVER(a_no_underflow, q_pop && q_empty, "sample queue read while empty")

endmodule

>>> hdl/uemf_front.sv
// front end: echo width to q8 distance and range check
module uemf_front import uemf_pkg::*;
(
    input  logic              push,
    output logic              full,
    input  logic [ECHO_W-1:0] echo_us,
    input  bounds_t           bounds,
    input  logic              q_full,
    output logic              q_push,
    output sample_t           q_word
);

    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] dist_q8;

    always_comb
    begin
        prod = PROD_W'(echo_us) * PROD_W'(SCALE_MUL);
        dist_q8 = prod[PROD_W-1:SCALE_SHIFT];
        q_word.dist_q8 = dist_q8;
        q_word.ok      = (echo_us != '0) && (dist_q8 >= bounds.min_dist)
                         && (dist_q8 <= bounds.max_dist);
    end

    assign full   = q_full;
    assign q_push = push && !q_full;

endmodule

>>> hdl/uemf_queue.sv
// two-entry queue of classified samples between front and back
module uemf_queue import uemf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  sample_t push_word,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output sample_t pop_word
);

    sample_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_PTR_W:0]     level_reg;
    logic [Q_PTR_W:0]     level_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (level_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty    = (level_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

>>> hdl/uemf_back.sv
// back end: batch store, median by ranking sequencer, result register
module uemf_back import uemf_pkg::*;
#(
    parameter int BATCH_SIZE = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  sample_t              q_word,
    output logic                 q_pop,
    input  thresh_t              thresh,
    output logic                 empty,
    input  logic                 pop,
    output logic [DIST_W-1:0]    distance_q8,
    output logic [STATUS_W-1:0]  status,
    output logic [VCOUNT_W-1:0]  valid_count
);

    localparam int IDX_W  = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
    localparam int CNT_W  = $clog2(BATCH_SIZE + 1);
    localparam int WIDE_W = CNT_W + THRESH_W + 1;

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [DIST_W-1:0]   dist_mem [BATCH_SIZE];
    logic                ok_mem   [BATCH_SIZE];

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [IDX_W-1:0]    wr_idx_reg;
    logic [IDX_W-1:0]    wr_idx_next;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    scan_idx_next;
    logic [CNT_W-1:0]    nvalid_reg;
    logic [CNT_W-1:0]    nvalid_next;
    logic [DIST_W-1:0]   lo_reg;
    logic [DIST_W-1:0]   lo_next;
    logic [DIST_W-1:0]   hi_reg;
    logic [DIST_W-1:0]   hi_next;
    logic [DIST_W-1:0]   last_dist_reg;
    logic [DIST_W-1:0]   last_dist_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DIST_W-1:0]   out_dist_reg;
    logic [DIST_W-1:0]   out_dist_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic [VCOUNT_W-1:0] out_count_reg;
    logic [VCOUNT_W-1:0] out_count_next;

    logic [DIST_W-1:0]   cand;
    logic                cand_ok;
    logic [CNT_W-1:0]    lt_cnt;
    logic [CNT_W-1:0]    le_cnt;
    logic [CNT_W-1:0]    k_lo;
    logic [CNT_W-1:0]    k_hi;
    logic [DIST_W:0]     mid_sum;
    logic [WIDE_W-1:0]   n_wide;
    logic                is_err;
    logic                load_out;
    logic                store_wr;

    assign empty       = !out_valid_reg;
    assign distance_q8 = out_dist_reg;
    assign status      = out_status_reg;
    assign valid_count = out_count_reg;

    assign cand    = dist_mem[scan_idx_reg];
    assign cand_ok = ok_mem[scan_idx_reg];
    assign k_lo    = (nvalid_reg - CNT_W'(1)) >> 1;
    assign k_hi    = nvalid_reg >> 1;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign n_wide  = WIDE_W'(nvalid_reg);
    assign is_err  = (nvalid_reg == '0) || (n_wide < WIDE_W'(thresh.warn_min));

    // rank of the candidate among the valid samples
    always_comb
    begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < BATCH_SIZE; j++)
        begin
            if (ok_mem[j] && (dist_mem[j] < cand))
            begin
                lt_cnt = lt_cnt + CNT_W'(1);
            end
            if (ok_mem[j] && (dist_mem[j] <= cand))
            begin
                le_cnt = le_cnt + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        wr_idx_next     = wr_idx_reg;
        scan_idx_next   = scan_idx_reg;
        nvalid_next     = nvalid_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        last_dist_next  = last_dist_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_dist_next   = out_dist_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        q_pop           = 1'b0;
        store_wr        = 1'b0;
        load_out        = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    store_wr    = 1'b1;
                    nvalid_next = nvalid_reg + CNT_W'(q_word.ok);
                    if (wr_idx_reg == IDX_W'(BATCH_SIZE - 1))
                    begin
                        wr_idx_next   = '0;
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        wr_idx_next = wr_idx_reg + IDX_W'(1);
                    end
                end
            end
            S_SCAN:
            begin
                if (cand_ok && (lt_cnt <= k_lo) && (k_lo < le_cnt))
                begin
                    lo_next = cand;
                end
                if (cand_ok && (lt_cnt <= k_hi) && (k_hi < le_cnt))
                begin
                    hi_next = cand;
                end
                if (scan_idx_reg == IDX_W'(BATCH_SIZE - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    out_count_next = (n_wide > WIDE_W'(7)) ? VCOUNT_W'(7)
                                                           : n_wide[VCOUNT_W-1:0];
                    if (is_err)
                    begin
                        out_status_next = STATUS_ERR;
                        out_dist_next   = last_dist_reg;
                    end
                    else
                    begin
                        last_dist_next  = mid_sum[DIST_W:1];
                        out_dist_next   = mid_sum[DIST_W:1];
                        out_status_next = (n_wide >= WIDE_W'(thresh.ok_min)) ? STATUS_GOOD
                                                                             : STATUS_WARN;
                    end
                    nvalid_next = '0;
                    state_next  = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            wr_idx_reg    <= '0;
            scan_idx_reg  <= '0;
            nvalid_reg    <= '0;
            last_dist_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            scan_idx_reg  <= scan_idx_next;
            nvalid_reg    <= nvalid_next;
            last_dist_reg <= last_dist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (load_out)
        begin
            out_dist_reg   <= out_dist_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            dist_mem[wr_idx_reg] <= q_word.dist_q8;
            ok_mem[wr_idx_reg]   <= q_word.ok;
        end
    end

endmodule

>>> test/ultrasonic_echo_median_filter_unit_tb.sv
// self-checking testbench of the ultrasonic echo median filter unit
module ultrasonic_echo_median_filter_unit_tb;
    import uemf_pkg::*;

    localparam int BATCH = 5;
    localparam int SETTLE_CYCLES = 4 * BATCH + 20;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_ECHO = 30000;
    localparam int MAX_DIST = 262143;

    typedef struct packed {
        logic [DIST_W-1:0]   dist_q8;
        logic [STATUS_W-1:0] stat;
        logic [VCOUNT_W-1:0] vcnt;
    } batch_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [ECHO_W-1:0]     echo_us = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [DIST_W-1:0]     distance_q8;
    logic [STATUS_W-1:0]   status;
    logic [VCOUNT_W-1:0]   valid_count;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    logic rx_hold = 1'b0;
    logic no_idle = 1'b0;

    logic [ECHO_W-1:0] pending_echo[$];
    batch_result_t     batch_results_q[$];
    batch_result_t     head_res;

    bit [DIST_W-1:0]   cfg_min = MIN_DIST_RST;
    bit [DIST_W-1:0]   cfg_max = MAX_DIST_RST;
    bit [THRESH_W-1:0] cfg_ok = OK_MIN_RST;
    bit [THRESH_W-1:0] cfg_warn = WARN_MIN_RST;

    bit [DIST_W-1:0]   samp_dist [BATCH];
    bit                samp_ok [BATCH];
    int                samp_cnt = 0;
    bit [DIST_W-1:0]   last_dist = '0;
    bit [STATUS_W-1:0] last_stat = STATUS_ERR;

    int tx_gap = 0;
    int rx_gap = 0;
    int err_count = 0;

    int directed_echo [25] = '{
        0, 30000, 1000, 2000, 3000,
        117, 116, 30000, 0, 5000,
        1000, 2000, 3000, 0, 0,
        0, 0, 0, 0, 0,
        30000, 1000, 20000, 5, 12345
    };

    ultrasonic_echo_median_filter_unit #(.BATCH_SIZE(BATCH)) uut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic predict_echo(input logic [ECHO_W-1:0] echo);
        bit [31:0]         prod;
        bit [DIST_W-1:0]   dist_q8;
        bit [DIST_W-1:0]   vals [BATCH];
        bit [DIST_W-1:0]   key;
        bit [DIST_W:0]     pair_sum;
        int                n;
        int                k;
        batch_result_t     res;
        prod = 32'(echo);
        prod = prod * 32'(SCALE_MUL);
        dist_q8 = DIST_W'(prod >> SCALE_SHIFT);
        samp_dist[samp_cnt] = dist_q8;
        samp_ok[samp_cnt] = (echo != '0) && (dist_q8 >= cfg_min) && (dist_q8 <= cfg_max);
        samp_cnt++;
        if (samp_cnt < BATCH)
            return;
        samp_cnt = 0;
        n = 0;
        for (int i = 0; i < BATCH; i++)
        begin
            if (samp_ok[i])
            begin
                vals[n] = samp_dist[i];
                n++;
            end
        end
        for (int i = 1; i < n; i++)
        begin
            key = vals[i];
            k = i;
            while (k > 0 && vals[k-1] > key)
            begin
                vals[k] = vals[k-1];
                k--;
            end
            vals[k] = key;
        end
        if (n == 0 || n < int'(cfg_warn))
            last_stat = STATUS_ERR;
        else
        begin
            if (n % 2 == 1)
                last_dist = vals[n/2];
            else
            begin
                pair_sum = (DIST_W+1)'(vals[n/2-1]) + (DIST_W+1)'(vals[n/2]);
                last_dist = pair_sum[DIST_W:1];
            end
            last_stat = (n >= int'(cfg_ok)) ? STATUS_GOOD : STATUS_WARN;
        end
        res.dist_q8 = last_dist;
        res.stat = last_stat;
        res.vcnt = (n > 7) ? VCOUNT_W'(7) : VCOUNT_W'(n);
        batch_results_q.push_back(res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            REG_MIN_DIST: cfg_min = val;
            REG_MAX_DIST: cfg_max = val;
            REG_OK_MIN:   cfg_ok = val[THRESH_W-1:0];
            REG_WARN_MIN: cfg_warn = val[THRESH_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic write_all(input int vmin, input int vmax, input int vok, input int vwarn);
        write_reg(REG_MIN_DIST, CFG_DATA_W'(vmin));
        write_reg(REG_MAX_DIST, CFG_DATA_W'(vmax));
        write_reg(REG_OK_MIN, CFG_DATA_W'(vok));
        write_reg(REG_WARN_MIN, CFG_DATA_W'(vwarn));
    endtask

    task automatic drain_and_settle();
        while (pending_echo.size() != 0 || push || batch_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            echo_us <= '0;
            tx_gap <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_echo(echo_us);
                void'(pending_echo.pop_front());
            end
            if (push && full)
                ;
            else if (tx_gap > 0)
            begin
                push <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                push <= 1'b0;
                tx_gap <= $urandom_range(0, 11);
            end
            else if (pending_echo.size() > 0)
            begin
                push <= 1'b1;
                echo_us <= pending_echo[0];
            end
            else
                push <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            rx_gap <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (batch_results_q.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected word: dist %0d status %0d count %0d",
                                 distance_q8, status, valid_count);
                    err_count++;
                end
                else
                begin
                    head_res = batch_results_q.pop_front();
                    if (distance_q8 !== head_res.dist_q8 || status !== head_res.stat ||
                        valid_count !== head_res.vcnt)
                    begin
                        if (err_count < 10)
                            $display("mismatch: dist %0d/%0d status %0d/%0d count %0d/%0d",
                                     head_res.dist_q8, distance_q8, head_res.stat, status,
                                     head_res.vcnt, valid_count);
                        err_count++;
                    end
                end
            end
            if (rx_hold)
                pop <= 1'b0;
            else if (rx_gap > 0)
            begin
                pop <= 1'b0;
                rx_gap <= rx_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                rx_gap <= $urandom_range(0, 11);
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        int pick;
        int e;
        int lo;
        int hi;
        int dpick;
        int count;
        int rmin;
        int rmax;
        int rwarn;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed batches
        for (int b = 0; b < 5; b++)
        begin
            case (b)
                1: write_all(513, 131718, 4, 2);
                2: write_all(512, 102400, 1, 4);
                3:
                begin
                    write_reg(REG_OK_MIN, CFG_DATA_W'(0));
                    write_reg(REG_WARN_MIN, CFG_DATA_W'(0));
                end
                4:
                begin
                    write_reg(REG_MIN_DIST, CFG_DATA_W'(200000));
                    write_reg(REG_MAX_DIST, CFG_DATA_W'(100));
                end
                default: ;
            endcase
            for (int i = 0; i < BATCH; i++)
                pending_echo.push_back(ECHO_W'(directed_echo[b*BATCH+i]));
            drain_and_settle();
        end

        // random phases
        for (int ph = 0; ph < 10; ph++)
        begin
            count = 100;
            rmin = $urandom_range(0, 20000);
            rmax = $urandom_range(rmin, 140000);
            if ($urandom_range(0, 9) == 0)
                rmax = $urandom_range(0, rmin);
            case (ph)
                0: write_all(0, MAX_DIST, 5, 5);
                2:
                begin
                    write_all(MAX_DIST, MAX_DIST, 0, 0);
                    count = 40;
                end
                4:
                begin
                    write_all(int'(MIN_DIST_RST), int'(MAX_DIST_RST), int'(OK_MIN_RST),
                              int'(WARN_MIN_RST));
                    count = 60;
                end
                5:
                begin
                    write_all(4390, 4390, 1, 1);
                    count = 80;
                end
                6:
                begin
                    rwarn = $urandom_range(1, 5);
                    write_all(rmin, rmax, $urandom_range(0, rwarn - 1), rwarn);
                end
                default:
                    write_all(rmin, rmax, $urandom_range(0, 5), $urandom_range(0, 5));
            endcase
            if (ph == 4)
                rx_hold <= 1'b1;
            if (ph == 9)
            begin
                no_idle <= 1'b1;
                count = 150;
            end
            for (int i = 0; i < count; i++)
            begin
                pick = $urandom_range(0, 99);
                lo = int'(cfg_min);
                hi = (cfg_max > 131718) ? 131718 : int'(cfg_max);
                if (pick < 12)
                    e = 0;
                else if (pick < 35 || lo > hi)
                    e = $urandom_range(0, MAX_ECHO);
                else
                begin
                    if (pick < 42)
                        dpick = lo;
                    else if (pick < 49)
                        dpick = hi;
                    else
                        dpick = $urandom_range(lo, hi);
                    e = (dpick * 1024) / 4496 + $urandom_range(0, 1);
                    if (e > MAX_ECHO)
                        e = MAX_ECHO;
                end
                pending_echo.push_back(e[ECHO_W-1:0]);
            end
            if (ph == 4)
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            drain_and_settle();
        end

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
